FILE: src/ulvl_pkg.sv
// shared types and constants of the ultrasonic tank level averager
package ulvl_pkg;

   // field widths
   localparam int ECHO_W     = 16;
   localparam int DIST_W     = 17;
   localparam int HEIGHT_W   = 16;
   localparam int PERMILLE_W = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_W      = 17;
   localparam int COUNT_W    = 5;

   // echo time to distance: 0.01 cm = (us * 1756) >> 10
   localparam logic [10:0] DIST_MUL   = 11'd1756;
   localparam int          DIST_SHIFT = 10;

   // level scale to tenths of a percent
   localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE = 10'd1000;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [COUNT_W-1:0]  RST_BURST_LEN    = 5'd5;
   localparam logic [HEIGHT_W-1:0] RST_TANK_HEIGHT  = 16'd10000;
   localparam logic [HEIGHT_W-1:0] RST_SENSOR_OFS   = 16'd500;
   localparam logic [DIST_W-1:0]   RST_MIN_DIST     = 17'd200;
   localparam logic [DIST_W-1:0]   RST_MAX_DIST     = 17'd40000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BURST_LEN     = 3'd0,
      CSR_TANK_HEIGHT   = 3'd1,
      CSR_SENSOR_OFFSET = 3'd2,
      CSR_MIN_DIST      = 3'd3,
      CSR_MAX_DIST      = 3'd4
   } csr_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TIMEOUT = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   // configuration register set
   typedef struct packed {
      logic [COUNT_W-1:0]  burst_len;
      logic [HEIGHT_W-1:0] tank_height_centicm;
      logic [HEIGHT_W-1:0] sensor_offset_centicm;
      logic [DIST_W-1:0]   min_distance_centicm;
      logic [DIST_W-1:0]   max_distance_centicm;
   } cfg_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_DIV_AVG,
      BACK_LEVEL,
      BACK_DIV_PCT,
      BACK_OUT
   } back_state_type;

endpackage

FILE: src/ulvl_if.sv
// channel interfaces for echo words and level result words
interface ulvl_req_if;
   import ulvl_pkg::*;
   logic                valid;
   logic                ready;
   logic [ECHO_W-1:0]   echo_us;
   modport source (output valid, output echo_us, input ready);
   modport sink   (input valid, input echo_us, output ready);
endinterface

interface ulvl_rsp_if;
   import ulvl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  level_ok;
   status_type            status;
   logic [DIST_W-1:0]     distance_centicm;
   logic [DIST_W-1:0]     level_centicm;
   logic [PERMILLE_W-1:0] level_permille;
   modport source (output valid, output level_ok, output status, output distance_centicm,
                   output level_centicm, output level_permille, input ready);
   modport sink   (input valid, input level_ok, input status, input distance_centicm,
                   input level_centicm, input level_permille, output ready);
endinterface

FILE: src/ulvl_front.sv
// front end: takes echo words, converts to distance and accumulates a burst
module ulvl_front #(
   parameter int MAX_SAMPLES = 16,
   parameter int CNT_W       = 5,
   parameter int SUM_W       = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  ulvl_pkg::cfg_type cfg,
   ulvl_req_if.sink          req,
   output logic              push_valid,
   input  logic              push_ready,
   output logic [SUM_W-1:0]  push_sum,
   output logic [CNT_W-1:0]  push_cnt
);
   import ulvl_pkg::*;

   localparam int EFF_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int PROD_W = ECHO_W + 11;

   logic [ECHO_W-1:0] echo_ff, echo_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [CNT_W-1:0]  valid_ff, valid_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic [PROD_W-1:0] prod;
   logic [DIST_W-1:0] echo_dist;
   logic              echo_hit;
   logic [CNT_W-1:0]  seen_next;
   logic [CNT_W-1:0]  valid_next;
   logic [SUM_W-1:0]  sum_next;
   logic [EFF_W-1:0]  count_ext;
   logic [EFF_W-1:0]  eff_count;
   logic              last;
   logic              step;
   logic              accept;

   // distance of the held echo word and the running totals with it
   always_comb begin
      prod       = PROD_W'(echo_ff) * PROD_W'(DIST_MUL);
      echo_dist  = prod[DIST_SHIFT +: DIST_W];
      echo_hit   = (echo_ff != '0);
      seen_next  = seen_ff + CNT_W'(1);
      valid_next = valid_ff + CNT_W'(echo_hit);
      sum_next   = sum_ff + (echo_hit ? SUM_W'(echo_dist) : '0);
   end

   // effective burst length, zero acts as one, clamped to the maximum
   always_comb begin
      count_ext = EFF_W'(cfg.burst_len);
      if (cfg.burst_len == '0) begin
         eff_count = EFF_W'(1);
      end else if (count_ext > EFF_W'(MAX_SAMPLES)) begin
         eff_count = EFF_W'(MAX_SAMPLES);
      end else begin
         eff_count = count_ext;
      end
      last = (EFF_W'(seen_next) >= eff_count);
   end

   // handshakes
   assign step       = pend_ff && (!last || push_ready);
   assign accept     = req.valid && req.ready;
   assign req.ready  = !pend_ff || step;
   assign push_valid = pend_ff && last;
   assign push_sum   = sum_next;
   assign push_cnt   = valid_next;

   // next state of the holding register and the burst totals
   always_comb begin
      echo_in  = accept ? req.echo_us : echo_ff;
      pend_in  = accept || (pend_ff && !step);
      seen_in  = seen_ff;
      valid_in = valid_ff;
      sum_in   = sum_ff;
      if (step) begin
         if (last) begin
            seen_in  = '0;
            valid_in = '0;
            sum_in   = '0;
         end else begin
            seen_in  = seen_next;
            valid_in = valid_next;
            sum_in   = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      echo_ff <= echo_in;
      if (reset) begin
         pend_ff  <= 1'b0;
         seen_ff  <= '0;
         valid_ff <= '0;
         sum_ff   <= '0;
      end else begin
         pend_ff  <= pend_in;
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

FILE: src/ulvl_queue.sv
// two word queue between the front and the back end
module ulvl_queue #(
   parameter int WIDTH = 27
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import ulvl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(do_push) - FILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: src/ulvl_div.sv
// restoring divider, one quotient bit per cycle
module ulvl_div #(
   parameter int DIVIDEND_W = 26,
   parameter int DIVISOR_W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one shift and trial subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/ulvl_back.sv
// back end: averages a burst, checks the window and scales the level
module ulvl_back #(
   parameter int CNT_W = 5,
   parameter int SUM_W = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ulvl_pkg::cfg_type      cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [SUM_W+CNT_W-1:0] pop_data,
   ulvl_rsp_if.source             rsp
);
   import ulvl_pkg::*;

   localparam int SCALED_W = HEIGHT_W + PERMILLE_W;
   localparam int DIV_W    = (SUM_W > SCALED_W) ? SUM_W : SCALED_W;
   localparam int DVS_W    = (CNT_W > HEIGHT_W) ? CNT_W : HEIGHT_W;

   back_state_type state_ff, state_in;

   logic [HEIGHT_W-1:0]   depth_ff, depth_in;
   logic                  ok_ff, ok_in;
   status_type            status_ff, status_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [DIST_W-1:0]     level_ff, level_in;
   logic [PERMILLE_W-1:0] pm_ff, pm_in;

   logic [SUM_W-1:0]      pop_sum;
   logic [CNT_W-1:0]      pop_cnt;
   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic [DVS_W-1:0]      div_divisor;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quotient;

   logic [DIST_W-1:0]     avg;
   logic [DIST_W-1:0]     top_dist;
   logic [DIST_W-1:0]     lv;
   logic [SCALED_W-1:0]   scaled;

   assign pop_sum = pop_data[CNT_W +: SUM_W];
   assign pop_cnt = pop_data[CNT_W-1:0];

   // shared divider for the average and for the percentage
   ulvl_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // level arithmetic on the fresh average
   always_comb begin
      avg      = div_quotient[DIST_W-1:0];
      top_dist = {1'b0, cfg.tank_height_centicm} + {1'b0, cfg.sensor_offset_centicm};
      lv       = (avg > top_dist) ? '0 : top_dist - avg;
      scaled   = SCALED_W'(depth_ff) * SCALED_W'(PERMILLE_SCALE);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      ok_in        = ok_ff;
      status_in    = status_ff;
      dist_in      = dist_ff;
      level_in     = level_ff;
      pm_in        = pm_ff;
      pop_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIV_W'(pop_sum);
      div_divisor  = DVS_W'(pop_cnt);
      unique case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               ok_in     = 1'b0;
               status_in = STATUS_TIMEOUT;
               dist_in   = '0;
               level_in  = '0;
               pm_in     = '0;
               if (pop_cnt == '0) begin
                  state_in = BACK_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = BACK_DIV_AVG;
               end
            end
         end
         BACK_DIV_AVG: begin
            if (div_done) begin
               if (avg < cfg.min_distance_centicm || avg > cfg.max_distance_centicm) begin
                  status_in = STATUS_RANGE;
                  state_in  = BACK_OUT;
               end else begin
                  dist_in  = avg;
                  level_in = lv;
                  depth_in = (lv > {1'b0, cfg.tank_height_centicm}) ?
                             cfg.tank_height_centicm : lv[HEIGHT_W-1:0];
                  state_in = BACK_LEVEL;
               end
            end
         end
         BACK_LEVEL: begin
            ok_in     = 1'b1;
            status_in = STATUS_OK;
            if (cfg.tank_height_centicm == '0) begin
               pm_in    = '0;
               state_in = BACK_OUT;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(scaled);
               div_divisor  = DVS_W'(cfg.tank_height_centicm);
               state_in     = BACK_DIV_PCT;
            end
         end
         BACK_DIV_PCT: begin
            if (div_done) begin
               pm_in    = div_quotient[PERMILLE_W-1:0];
               state_in = BACK_OUT;
            end
         end
         BACK_OUT: begin
            if (rsp.ready) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff  <= depth_in;
      ok_ff     <= ok_in;
      status_ff <= status_in;
      dist_ff   <= dist_in;
      level_ff  <= level_in;
      pm_ff     <= pm_in;
   end

   // result word
   assign rsp.valid            = (state_ff == BACK_OUT);
   assign rsp.level_ok         = ok_ff;
   assign rsp.status           = status_ff;
   assign rsp.distance_centicm = dist_ff;
   assign rsp.level_centicm    = level_ff;
   assign rsp.level_permille   = pm_ff;

endmodule

FILE: src/ultrasonic_tank_level_averager.sv
// Tank level averager. Each echo word (pulse width in us, zero = timeout) is turned
// into a distance in 0.01 cm and summed over a burst whose length is set by the burst
// length register; the last word of a burst yields one result word with status, average
// distance, level and level in tenths of a percent. The front end takes one echo word
// per cycle inside a burst; the last word of a burst waits until the queue has room.
// At the end of a burst the back end takes it and uses the single bit-serial divider,
// DIV_W = max(17 + clog2(MAX_SAMPLES+1), 26) bits wide, first to form the average and
// then the percentage; an out of window burst skips the level and the percentage, and a
// burst with no valid echo skips both divisions. The back end takes the next burst only
// after its result word is taken. A two-word queue between the ends holds up to two
// finished bursts, so echo words keep flowing while the back end divides or the result word waits.
module ultrasonic_tank_level_averager #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   ulvl_req_if.sink                           req_ch,
   ulvl_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [ulvl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ulvl_pkg::CSR_W-1:0]         csr_wdata
);
   import ulvl_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = DIST_W + CNT_W;

   cfg_type cfg_ff, cfg_in;

   logic                   push_valid;
   logic                   push_ready;
   logic [SUM_W-1:0]       push_sum;
   logic [CNT_W-1:0]       push_cnt;
   logic                   pop_valid;
   logic                   pop_ready;
   logic [SUM_W+CNT_W-1:0] pop_data;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BURST_LEN:     cfg_in.burst_len             = csr_wdata[COUNT_W-1:0];
            CSR_TANK_HEIGHT:   cfg_in.tank_height_centicm   = csr_wdata[HEIGHT_W-1:0];
            CSR_SENSOR_OFFSET: cfg_in.sensor_offset_centicm = csr_wdata[HEIGHT_W-1:0];
            CSR_MIN_DIST:      cfg_in.min_distance_centicm  = csr_wdata[DIST_W-1:0];
            CSR_MAX_DIST:      cfg_in.max_distance_centicm  = csr_wdata[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_len             <= RST_BURST_LEN;
         cfg_ff.tank_height_centicm   <= RST_TANK_HEIGHT;
         cfg_ff.sensor_offset_centicm <= RST_SENSOR_OFS;
         cfg_ff.min_distance_centicm  <= RST_MIN_DIST;
         cfg_ff.max_distance_centicm  <= RST_MAX_DIST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accumulate bursts
   ulvl_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sum   (push_sum),
      .push_cnt   (push_cnt)
   );

   // finished bursts waiting for the back end
   ulvl_queue #(
      .WIDTH (SUM_W + CNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_sum, push_cnt}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // average, window check and level
   ulvl_back #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_ch)
   );

   // ok flag only with ok status
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.level_ok == (rsp_ch.status == STATUS_OK)))
      else $error("level_ok does not match status");

   // failed measurements carry zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_OK) |->
      (rsp_ch.distance_centicm == '0 && rsp_ch.level_centicm == '0 &&
       rsp_ch.level_permille == '0))
      else $error("failed result with nonzero fields");

   // ok average lies inside the window
   a_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.level_ok) |->
      (rsp_ch.distance_centicm >= cfg_ff.min_distance_centicm &&
       rsp_ch.distance_centicm <= cfg_ff.max_distance_centicm))
      else $error("ok average outside window");

   // percentage never above full scale
   a_permille: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.level_permille <= PERMILLE_SCALE))
      else $error("level_permille above full scale");

endmodule
